### rtl/vrsa_pkg.sv
package vrsa_pkg;

	localparam int DOTS_PER_LINE        = 341;
	localparam int LINES_PER_FRAME_DEF  = 262;
	localparam int VBLANK_LINE_DEF      = 241;
	localparam int DOT_W                = 9;
	localparam int RENDER_LINES         = 240;
	localparam int NT_DEPTH             = 4096;
	localparam int NT_AW                = 12;
	localparam int OAM_DEPTH            = 256;
	localparam int OAM_AW               = 8;
	localparam int PAL_DEPTH            = 32;
	localparam int PAL_AW               = 5;

	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_TICK  = 2'd2;

	localparam logic [2:0] REG_CTRL   = 3'd0;
	localparam logic [2:0] REG_MASK   = 3'd1;
	localparam logic [2:0] REG_STATUS = 3'd2;
	localparam logic [2:0] REG_OAMADR = 3'd3;
	localparam logic [2:0] REG_OAMDAT = 3'd4;
	localparam logic [2:0] REG_SCROLL = 3'd5;
	localparam logic [2:0] REG_ADDR   = 3'd6;
	localparam logic [2:0] REG_DATA   = 3'd7;

	typedef enum logic [1:0] {
		RD_ZERO,
		RD_DIRECT,
		RD_OAM,
		RD_BUF
	} rd_sel_t;

	typedef enum logic [1:0] {
		BUF_KEEP,
		BUF_CHR,
		BUF_NT
	} buf_sel_t;

	typedef struct packed {
		logic [1:0] func;
		logic [2:0] reg_index;
		logic [7:0] write_data;
		logic [7:0] chr_read_data;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        pattern_write;
		logic [12:0] pattern_addr;
		logic [7:0]  pattern_data;
		logic [14:0] next_vram_addr;
		logic        vblank;
	} out_word_t;

	// coarse x step with horizontal nametable wrap
	function automatic logic [14:0] inc_coarse_x(input logic [14:0] a);
		logic [14:0] r;
		if (a[4:0] == 5'h1f) begin
			r = {a[14:11], ~a[10], a[9:5], 5'h00};
		end else begin
			r = a + 15'd1;
		end
		return r;
	endfunction

	// fine y step, carrying into coarse y and the vertical nametable bit
	function automatic logic [14:0] inc_fine_y(input logic [14:0] a);
		logic [14:0] r;
		logic [4:0]  y;
		r = a;
		if (a[14:12] != 3'd7) begin
			r[14:12] = a[14:12] + 3'd1;
		end else begin
			r[14:12] = 3'd0;
			y = a[9:5];
			if (y == 5'd29) begin
				y = 5'd0;
				r[11] = ~a[11];
			end else if (y == 5'd31) begin
				y = 5'd0;
			end else begin
				y = y + 5'd1;
			end
			r[9:5] = y;
		end
		return r;
	endfunction

	// palette entries 10/14/18/1c fold onto 00/04/08/0c
	function automatic logic [4:0] pal_index(input logic [13:0] a);
		logic [4:0] i;
		i = a[4:0];
		if (i[4] && (i[1:0] == 2'b00)) begin
			i[4] = 1'b0;
		end
		return i;
	endfunction

endpackage

### rtl/vrsa_oam_ram.sv
module vrsa_oam_ram (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       re,
	input  logic       we,
	input  logic [vrsa_pkg::OAM_AW-1:0] addr,
	input  logic [7:0] wdata,
	output logic [7:0] rdata
);

	logic [7:0] mem [vrsa_pkg::OAM_DEPTH];
	logic [vrsa_pkg::OAM_DEPTH-1:0] valid_q;
	logic [7:0] rdata_q;
	logic       rvalid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[addr] <= 1'b1;
			end
			if (re) begin
				rvalid_q <= valid_q[addr];
			end
		end
	end

	assign rdata = rvalid_q ? rdata_q : 8'h00;

endmodule

### rtl/vrsa_nt_ram.sv
module vrsa_nt_ram (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       re,
	input  logic       we,
	input  logic [vrsa_pkg::NT_AW-1:0] addr,
	input  logic [7:0] wdata,
	output logic [7:0] rdata,
	output logic       busy
);

	logic [7:0] mem [vrsa_pkg::NT_DEPTH];
	logic [7:0] rdata_q;
	logic [vrsa_pkg::NT_AW-1:0] clr_cnt_q;
	logic       clr_busy_q;

	// clearing sweep after reset, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_cnt_q] <= 8'h00;
		end else if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = clr_busy_q;

endmodule

### rtl/video_register_port_and_scroll_address_unit.sv
// Video register port and scroll address unit. Each input word is a cpu
// register read, a register write or one dot tick; each gives exactly one
// output word carrying the read value, any pattern memory write, the vram
// address after the word and the vblank flag. A word is taken every cycle
// unless in_stall is high; its result passes through stage 1, where the
// synchronous oam and nametable reads complete, and then the output
// register. After reset the nametable memory is swept to zero, during which
// in_stall is high; the mirror mask register may be written at any time.
module video_register_port_and_scroll_address_unit #(
	parameter int LINES_PER_FRAME = vrsa_pkg::LINES_PER_FRAME_DEF,
	parameter int VBLANK_LINE     = vrsa_pkg::VBLANK_LINE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  vrsa_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output vrsa_pkg::out_word_t out_word,
	input  logic                cfg_we,
	input  logic [11:0]         cfg_data
);

	localparam int LINE_W = $clog2(LINES_PER_FRAME);
	localparam int DOT_W  = vrsa_pkg::DOT_W;

	// architectural registers
	logic [14:0] cur_q, tmp_q;
	logic        first_q;
	logic [7:0]  ctrl_q, mask_q;
	logic        vblank_q;
	logic [7:0]  oam_ptr_q;
	logic [7:0]  buf_q;
	logic [11:0] mirror_q;
	logic [DOT_W-1:0]  dot_q;
	logic [LINE_W-1:0] line_q;
	logic [5:0]  pal_q [vrsa_pkg::PAL_DEPTH];

	// stage 1: item applied, memory reads in flight
	logic                s1_valid_q;
	vrsa_pkg::rd_sel_t   rd_sel_s1;
	vrsa_pkg::buf_sel_t  buf_sel_s1;
	logic [7:0]          rd_val_s1;
	logic [7:0]          chr_s1;
	logic                pw_s1;
	logic [12:0]         pa_s1;
	logic [7:0]          pd_s1;
	logic [14:0]         addr_s1;
	logic                vb_s1;

	// output register
	logic                out_valid_q;
	vrsa_pkg::out_word_t out_q;

	logic acc, move, nt_busy;
	logic [7:0] oam_rdata, nt_rdata;

	// next values for the accepted word
	logic [14:0] cur_d, tmp_d;
	logic        first_d, vblank_d;
	logic [7:0]  ctrl_d, mask_d, oam_ptr_d;
	vrsa_pkg::rd_sel_t  rd_sel_d;
	vrsa_pkg::buf_sel_t buf_sel_d;
	logic [7:0]  rd_val_d;
	logic        pw_d, nt_re, nt_we, oam_re, oam_we, pal_we;
	logic [13:0] a14;
	logic [4:0]  pal_idx;
	logic        tick;

	assign move     = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = nt_busy || (s1_valid_q && !move);
	assign acc      = in_valid && !in_stall;

	assign a14     = cur_q[13:0];
	assign pal_idx = vrsa_pkg::pal_index(a14);
	assign tick    = (in_word.func == vrsa_pkg::FUNC_TICK);

	always_comb begin
		logic        is_chr, is_pal, on, pre, rline;
		logic [14:0] step;
		is_chr = !a14[13];
		is_pal = (a14[13:8] == 6'h3f);
		step   = ctrl_q[2] ? 15'd32 : 15'd1;
		on     = mask_q[4] || mask_q[3];
		pre    = (line_q == LINE_W'(LINES_PER_FRAME - 1));
		rline  = (line_q < LINE_W'(vrsa_pkg::RENDER_LINES)) || pre;

		cur_d     = cur_q;
		tmp_d     = tmp_q;
		first_d   = first_q;
		ctrl_d    = ctrl_q;
		mask_d    = mask_q;
		vblank_d  = vblank_q;
		oam_ptr_d = oam_ptr_q;
		rd_sel_d  = vrsa_pkg::RD_ZERO;
		buf_sel_d = vrsa_pkg::BUF_KEEP;
		rd_val_d  = 8'h00;
		pw_d      = 1'b0;
		nt_re     = 1'b0;
		nt_we     = 1'b0;
		oam_re    = 1'b0;
		oam_we    = 1'b0;
		pal_we    = 1'b0;

		if (in_word.func == vrsa_pkg::FUNC_READ) begin
			if (in_word.reg_index == vrsa_pkg::REG_STATUS) begin
				rd_sel_d = vrsa_pkg::RD_DIRECT;
				rd_val_d = {vblank_q, 7'd0};
				first_d  = 1'b1;
				vblank_d = 1'b0;
			end else if (in_word.reg_index == vrsa_pkg::REG_OAMDAT) begin
				rd_sel_d = vrsa_pkg::RD_OAM;
				oam_re   = 1'b1;
			end else if (in_word.reg_index == vrsa_pkg::REG_DATA) begin
				if (is_chr) begin
					rd_sel_d  = vrsa_pkg::RD_BUF;
					buf_sel_d = vrsa_pkg::BUF_CHR;
				end else if (!is_pal) begin
					rd_sel_d  = vrsa_pkg::RD_BUF;
					buf_sel_d = vrsa_pkg::BUF_NT;
					nt_re     = 1'b1;
				end else begin
					// palette answers at once, buffer takes the nametable beneath
					rd_sel_d  = vrsa_pkg::RD_DIRECT;
					rd_val_d  = {2'b00, pal_q[pal_idx]};
					buf_sel_d = vrsa_pkg::BUF_NT;
					nt_re     = 1'b1;
				end
				cur_d = cur_q + step;
			end
		end else if (in_word.func == vrsa_pkg::FUNC_WRITE) begin
			unique case (in_word.reg_index)
				vrsa_pkg::REG_CTRL: begin
					ctrl_d        = in_word.write_data;
					tmp_d[11:10]  = in_word.write_data[1:0];
				end
				vrsa_pkg::REG_MASK: begin
					mask_d = in_word.write_data;
				end
				vrsa_pkg::REG_STATUS: begin
				end
				vrsa_pkg::REG_OAMADR: begin
					oam_ptr_d = in_word.write_data;
				end
				vrsa_pkg::REG_OAMDAT: begin
					oam_we    = 1'b1;
					oam_ptr_d = oam_ptr_q + 8'd1;
				end
				vrsa_pkg::REG_SCROLL: begin
					if (first_q) begin
						tmp_d[4:0] = in_word.write_data[7:3];
					end else begin
						tmp_d[14:12] = in_word.write_data[2:0];
						tmp_d[9:5]   = in_word.write_data[7:3];
					end
					first_d = !first_q;
				end
				vrsa_pkg::REG_ADDR: begin
					if (first_q) begin
						tmp_d[14]   = 1'b0;
						tmp_d[13:8] = in_word.write_data[5:0];
					end else begin
						tmp_d[7:0] = in_word.write_data;
						cur_d      = {tmp_q[14:8], in_word.write_data};
					end
					first_d = !first_q;
				end
				vrsa_pkg::REG_DATA: begin
					if (is_chr) begin
						pw_d = 1'b1;
					end else if (!is_pal) begin
						nt_we = 1'b1;
					end else begin
						pal_we = 1'b1;
					end
					cur_d = cur_q + step;
				end
				default: begin
				end
			endcase
		end else if (tick) begin
			if (on && rline) begin
				if ((dot_q != '0) && (dot_q < DOT_W'(258))) begin
					if (dot_q == DOT_W'(256)) begin
						cur_d = vrsa_pkg::inc_coarse_x(vrsa_pkg::inc_fine_y(cur_q));
					end else if (dot_q == DOT_W'(257)) begin
						cur_d = (cur_q & ~15'h041f) | (tmp_q & 15'h041f);
					end else if (dot_q[2:0] == 3'd0) begin
						cur_d = vrsa_pkg::inc_coarse_x(cur_q);
					end
				end else if ((dot_q == DOT_W'(328)) || (dot_q == DOT_W'(336))) begin
					cur_d = vrsa_pkg::inc_coarse_x(cur_q);
				end
			end
			// pre-render line: vertical copy, vblank clear
			if (pre) begin
				if ((dot_q >= DOT_W'(280)) && (dot_q <= DOT_W'(304))) begin
					if (on) begin
						cur_d = (cur_q & ~15'h7be0) | (tmp_q & 15'h7be0);
					end
				end else if (dot_q == DOT_W'(1)) begin
					vblank_d = 1'b0;
				end
			end else if ((line_q == LINE_W'(VBLANK_LINE)) && (dot_q == DOT_W'(1))) begin
				vblank_d = 1'b1;
			end
		end
	end

	vrsa_oam_ram u_oam (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (acc && oam_re),
		.we     (acc && oam_we),
		.addr   (oam_ptr_q),
		.wdata  (in_word.write_data),
		.rdata  (oam_rdata)
	);

	// nametable index is the mirror-masked low twelve bits
	vrsa_nt_ram u_nt (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (acc && nt_re),
		.we     (acc && nt_we),
		.addr   (a14[11:0] & mirror_q),
		.wdata  (in_word.write_data),
		.rdata  (nt_rdata),
		.busy   (nt_busy)
	);

	// palette, 32 entries of six bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < vrsa_pkg::PAL_DEPTH; i++) begin
				pal_q[i] <= 6'd0;
			end
		end else if (acc && pal_we) begin
			pal_q[pal_idx] <= in_word.write_data[5:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_q <= 12'hfff;
		end else if (cfg_we) begin
			mirror_q <= cfg_data;
		end
	end

	// register state and dot counters, updated as each word enters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			tmp_q     <= '0;
			first_q   <= 1'b1;
			ctrl_q    <= '0;
			mask_q    <= '0;
			vblank_q  <= 1'b0;
			oam_ptr_q <= '0;
			dot_q     <= '0;
			line_q    <= '0;
		end else if (acc) begin
			cur_q     <= cur_d;
			tmp_q     <= tmp_d;
			first_q   <= first_d;
			ctrl_q    <= ctrl_d;
			mask_q    <= mask_d;
			vblank_q  <= vblank_d;
			oam_ptr_q <= oam_ptr_d;
			if (tick) begin
				if (dot_q == DOT_W'(vrsa_pkg::DOTS_PER_LINE - 1)) begin
					dot_q <= '0;
					line_q <= (line_q == LINE_W'(LINES_PER_FRAME - 1)) ? '0 : line_q + 1'b1;
				end else begin
					dot_q <= dot_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (acc) begin
			s1_valid_q <= 1'b1;
		end else if (move) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_sel_s1  <= rd_sel_d;
			buf_sel_s1 <= buf_sel_d;
			rd_val_s1  <= rd_val_d;
			chr_s1     <= in_word.chr_read_data;
			pw_s1      <= pw_d;
			pa_s1      <= pw_d ? a14[12:0] : 13'd0;
			pd_s1      <= pw_d ? in_word.write_data : 8'd0;
			addr_s1    <= cur_d;
			vb_s1      <= vblank_d;
		end
	end

	// read buffer lives at the output side so a load is seen by the next read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (move) begin
				out_valid_q <= 1'b1;
				unique case (buf_sel_s1)
					vrsa_pkg::BUF_CHR: buf_q <= chr_s1;
					vrsa_pkg::BUF_NT:  buf_q <= nt_rdata;
					default:           buf_q <= buf_q;
				endcase
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			unique case (rd_sel_s1)
				vrsa_pkg::RD_DIRECT: out_q.read_data <= rd_val_s1;
				vrsa_pkg::RD_OAM:    out_q.read_data <= oam_rdata;
				vrsa_pkg::RD_BUF:    out_q.read_data <= buf_q;
				default:             out_q.read_data <= 8'h00;
			endcase
			out_q.pattern_write  <= pw_s1;
			out_q.pattern_addr   <= pa_s1;
			out_q.pattern_data   <= pd_s1;
			out_q.next_vram_addr <= addr_s1;
			out_q.vblank         <= vb_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// a full pipe with a stalled output takes nothing
	a_full_no_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && out_stall) |-> !acc)
		else $error("word accepted into a full pipe");

	// vblank only sets on a dot tick
	a_vblank_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vblank_q) |-> $past(acc && tick))
		else $error("vblank set without a dot tick");

	// vram address only moves with an accepted word
	a_addr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(cur_q))
		else $error("vram address changed while idle");

	// nothing enters during the nametable sweep
	a_sweep_block: assert property (@(posedge clk) disable iff (!arst_n)
		nt_busy |-> !acc)
		else $error("word accepted during nametable sweep");

endmodule

### tb/tb_video_register_port_and_scroll_address_unit.sv
module tb_video_register_port_and_scroll_address_unit;
	timeunit 1ns;
	timeprecision 1ps;

	// func code that the block must treat as a no-op
	localparam logic [1:0] FUNC_SPARE = 2'd3;
	localparam int FRAME_DOTS = vrsa_pkg::DOTS_PER_LINE * vrsa_pkg::LINES_PER_FRAME_DEF;
	localparam int PRE_LINE = vrsa_pkg::LINES_PER_FRAME_DEF - 1;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_WORDS = 1700;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	vrsa_pkg::in_word_t in_word;
	logic out_valid;
	logic out_stall;
	vrsa_pkg::out_word_t out_word;
	logic cfg_we;
	logic [11:0] cfg_data;

	video_register_port_and_scroll_address_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// ---------------------------------------------------------------
	// shadow of the register port and scroll state
	// ---------------------------------------------------------------
	logic [14:0] vaddr_cur;
	logic [14:0] vaddr_tmp;
	logic        latch_first;
	logic [7:0]  ctrl_sh;
	logic [7:0]  mask_sh;
	logic [7:0]  status_sh;
	logic [7:0]  oam_ptr;
	logic [7:0]  oam_sh [vrsa_pkg::OAM_DEPTH];
	logic [7:0]  read_buf;
	logic [7:0]  nt_sh [vrsa_pkg::NT_DEPTH];
	logic [5:0]  pal_sh [vrsa_pkg::PAL_DEPTH];
	int unsigned dot_count;
	logic [11:0] mirror_sh;

	vrsa_pkg::out_word_t expected_words[$];
	vrsa_pkg::in_word_t  pending_words[$];
	int          errors;
	int          checked;
	int unsigned cycles;

	// palette entries 10/14/18/1c alias the backdrop slots
	function automatic logic [4:0] palette_slot(input logic [13:0] a);
		logic [4:0] s;
		s = a[4:0];
		if (s[4] && s[1:0] == 2'b00)
			s = s & 5'h0f;
		return s;
	endfunction

	function automatic logic [11:0] nametable_slot(input logic [13:0] a);
		return a[11:0] & mirror_sh;
	endfunction

	function automatic void advance_coarse_x();
		if (vaddr_cur[4:0] == 5'h1f) begin
			vaddr_cur[4:0] = 5'h00;
			vaddr_cur[10] = ~vaddr_cur[10];
		end else begin
			vaddr_cur = vaddr_cur + 15'd1;
		end
	endfunction

	function automatic void advance_fine_y();
		logic [4:0] row;
		if (vaddr_cur[14:12] != 3'd7) begin
			vaddr_cur[14:12] = vaddr_cur[14:12] + 3'd1;
		end else begin
			vaddr_cur[14:12] = 3'd0;
			row = vaddr_cur[9:5];
			if (row == 5'd29) begin
				row = 5'd0;
				vaddr_cur[11] = ~vaddr_cur[11];
			end else if (row == 5'd31) begin
				row = 5'd0;
			end else begin
				row = row + 5'd1;
			end
			vaddr_cur[9:5] = row;
		end
	endfunction

	function automatic void bump_vram_addr();
		vaddr_cur = vaddr_cur + (ctrl_sh[2] ? 15'd32 : 15'd1);
	endfunction

	function automatic void run_dot();
		int line;
		int dot;
		logic on;
		line = dot_count / vrsa_pkg::DOTS_PER_LINE;
		dot = dot_count % vrsa_pkg::DOTS_PER_LINE;
		on = mask_sh[3] | mask_sh[4];
		if (on && (line < vrsa_pkg::RENDER_LINES || line == PRE_LINE)) begin
			if (dot != 0 && dot < 258) begin
				if (dot == 256) begin
					advance_fine_y();
					advance_coarse_x();
				end else if (dot == 257) begin
					vaddr_cur = (vaddr_cur & ~15'h041f) | (vaddr_tmp & 15'h041f);
				end else if (dot % 8 == 0) begin
					advance_coarse_x();
				end
			end else if (dot == 328 || dot == 336) begin
				advance_coarse_x();
			end
		end
		if (line == PRE_LINE) begin
			if (dot >= 280 && dot <= 304) begin
				if (on)
					vaddr_cur = (vaddr_cur & ~15'h7be0) | (vaddr_tmp & 15'h7be0);
			end else if (dot == 1) begin
				status_sh = status_sh & 8'h1f;
			end
		end else if (line == vrsa_pkg::VBLANK_LINE_DEF && dot == 1) begin
			status_sh[7] = 1'b1;
		end
		dot_count = (dot_count + 1) % FRAME_DOTS;
	endfunction

	// applies one word to the shadow state and returns the word it should produce
	function automatic vrsa_pkg::out_word_t port_access(input vrsa_pkg::in_word_t w);
		vrsa_pkg::out_word_t o;
		logic [13:0] a;
		o = '0;
		a = vaddr_cur[13:0];
		case (w.func)
			vrsa_pkg::FUNC_READ: begin
				case (w.reg_index)
					vrsa_pkg::REG_STATUS: begin
						latch_first = 1'b1;
						o.read_data = status_sh;
						status_sh[7] = 1'b0;
					end
					vrsa_pkg::REG_OAMDAT: o.read_data = oam_sh[oam_ptr];
					vrsa_pkg::REG_DATA: begin
						if (a < 14'h2000) begin
							o.read_data = read_buf;
							read_buf = w.chr_read_data;
						end else if (a < 14'h3f00) begin
							o.read_data = read_buf;
							read_buf = nt_sh[nametable_slot(a)];
						end else begin
							// palette answers at once, buffer takes the nametable beneath
							o.read_data = {2'b00, pal_sh[palette_slot(a)]};
							read_buf = nt_sh[nametable_slot(a & 14'h2fff)];
						end
						bump_vram_addr();
					end
					default: ;
				endcase
			end
			vrsa_pkg::FUNC_WRITE: begin
				case (w.reg_index)
					vrsa_pkg::REG_CTRL: begin
						ctrl_sh = w.write_data;
						vaddr_tmp[11:10] = w.write_data[1:0];
					end
					vrsa_pkg::REG_MASK: mask_sh = w.write_data;
					vrsa_pkg::REG_OAMADR: oam_ptr = w.write_data;
					vrsa_pkg::REG_OAMDAT: begin
						oam_sh[oam_ptr] = w.write_data;
						oam_ptr = oam_ptr + 8'd1;
					end
					vrsa_pkg::REG_SCROLL: begin
						if (latch_first) begin
							vaddr_tmp[4:0] = w.write_data[7:3];
						end else begin
							vaddr_tmp[14:12] = w.write_data[2:0];
							vaddr_tmp[9:5] = w.write_data[7:3];
						end
						latch_first = ~latch_first;
					end
					vrsa_pkg::REG_ADDR: begin
						if (latch_first) begin
							vaddr_tmp[14] = 1'b0;
							vaddr_tmp[13:8] = w.write_data[5:0];
						end else begin
							vaddr_tmp[7:0] = w.write_data;
							vaddr_cur = vaddr_tmp;
						end
						latch_first = ~latch_first;
					end
					vrsa_pkg::REG_DATA: begin
						if (a < 14'h2000) begin
							o.pattern_write = 1'b1;
							o.pattern_addr = a[12:0];
							o.pattern_data = w.write_data;
						end else if (a < 14'h3f00) begin
							nt_sh[nametable_slot(a)] = w.write_data;
						end else begin
							pal_sh[palette_slot(a)] = w.write_data[5:0];
						end
						bump_vram_addr();
					end
					default: ;
				endcase
			end
			vrsa_pkg::FUNC_TICK: run_dot();
			default: ;
		endcase
		o.next_vram_addr = vaddr_cur;
		o.vblank = status_sh[7];
		return o;
	endfunction

	task automatic report(input string field, input int got, input int want);
		$display("word %0d: %s is %0h, wanted %0h", checked, field, got, want);
		errors++;
	endtask

	// ---------------------------------------------------------------
	// driver: bursts of words from the pending queue with random gaps
	// ---------------------------------------------------------------
	int burst_left;
	int gap_left;

	always @(posedge clk) begin
		if (arst_n) begin
			// a word went in at this edge, so predict what it gives
			if (in_valid && !in_stall)
				expected_words.push_back(port_access(in_word));
			// a stalled word stays put
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					in_valid <= 1'b1;
					in_word <= pending_words.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 60);
						// about half the bursts run straight into the next
						gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: stall pattern of its own, one long hold-off, checking
	// ---------------------------------------------------------------
	int  stall_mode;
	int  mode_left;
	int  hold_left;
	logic hold_done;

	always @(posedge clk) begin
		vrsa_pkg::out_word_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					report("unexpected output word", 1, 0);
				end else begin
					want = expected_words.pop_front();
					if (out_word.read_data !== want.read_data)
						report("read_data", out_word.read_data, want.read_data);
					if (out_word.pattern_write !== want.pattern_write)
						report("pattern_write", out_word.pattern_write, want.pattern_write);
					if (out_word.pattern_addr !== want.pattern_addr)
						report("pattern_addr", out_word.pattern_addr, want.pattern_addr);
					if (out_word.pattern_data !== want.pattern_data)
						report("pattern_data", out_word.pattern_data, want.pattern_data);
					if (out_word.next_vram_addr !== want.next_vram_addr)
						report("next_vram_addr", out_word.next_vram_addr, want.next_vram_addr);
					if (out_word.vblank !== want.vblank)
						report("vblank", out_word.vblank, want.vblank);
				end
				checked <= checked + 1;
			end
			// one long hold-off while the sender keeps offering words
			if (!hold_done && checked >= 400) begin
				hold_done <= 1'b1;
				hold_left <= 300;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode <= $urandom_range(0, 2);
					mode_left <= $urandom_range(10, 200);
				end else begin
					mode_left <= mode_left - 1;
				end
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("video_register_port_and_scroll_address_unit: mismatch");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	int queued;

	function automatic vrsa_pkg::in_word_t mk(input logic [1:0] f, input logic [2:0] r,
		input logic [7:0] wd, input logic [7:0] chr);
		vrsa_pkg::in_word_t w;
		w.func = f;
		w.reg_index = r;
		w.write_data = wd;
		w.chr_read_data = chr;
		return w;
	endfunction

	task automatic put(input vrsa_pkg::in_word_t w);
		pending_words.push_back(w);
		queued++;
	endtask

	task automatic put_random(input logic [1:0] f, input logic [2:0] r);
		put(mk(f, r, 8'($urandom), 8'($urandom)));
	endtask

	// mostly well-formed register sequences with random content
	task automatic put_group();
		int kind;
		int n;
		logic [7:0] hi;
		kind = $urandom_range(0, 11);
		case (kind)
			0, 1, 2: begin
				put_random(vrsa_pkg::FUNC_READ, vrsa_pkg::REG_STATUS);
				case ($urandom_range(0, 3))
					0: hi = 8'($urandom_range(8'h00, 8'h1f));
					1: hi = 8'($urandom_range(8'h20, 8'h3e));
					2: hi = 8'h3f;
					default: hi = 8'($urandom);
				endcase
				put(mk(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_ADDR, hi, 8'($urandom)));
				put_random(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_ADDR);
				n = $urandom_range(1, 8);
				repeat (n)
					put_random($urandom_range(0, 1) ? vrsa_pkg::FUNC_READ : vrsa_pkg::FUNC_WRITE,
						vrsa_pkg::REG_DATA);
			end
			3: begin
				put_random(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_SCROLL);
				put_random(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_SCROLL);
			end
			4: put_random(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_CTRL);
			5: put(mk(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_MASK,
				8'($urandom) | ($urandom_range(0, 2) ? 8'h18 : 8'h00), 8'($urandom)));
			6: begin
				put_random(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_OAMADR);
				n = $urandom_range(1, 6);
				repeat (n)
					put_random($urandom_range(0, 1) ? vrsa_pkg::FUNC_READ : vrsa_pkg::FUNC_WRITE,
						vrsa_pkg::REG_OAMDAT);
			end
			7, 8: begin
				n = $urandom_range(1, 60);
				repeat (n)
					put_random(vrsa_pkg::FUNC_TICK, 3'($urandom));
			end
			9: put(mk(2'($urandom), 3'($urandom), 8'($urandom), 8'($urandom)));
			10: put_random(vrsa_pkg::FUNC_READ, vrsa_pkg::REG_STATUS);
			default: put_random(vrsa_pkg::FUNC_READ, 3'($urandom));
		endcase
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || in_valid || expected_words.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_mirror(input logic [11:0] m);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= m;
		mirror_sh = m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [11:0] masks [6];
		int stop_at;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		errors = 0;
		checked = 0;
		cycles = 0;
		queued = 0;
		burst_left = 1;
		gap_left = 0;
		stall_mode = 0;
		mode_left = 0;
		hold_left = 0;
		hold_done = 1'b0;

		vaddr_cur = '0;
		vaddr_tmp = '0;
		latch_first = 1'b1;
		ctrl_sh = '0;
		mask_sh = '0;
		status_sh = '0;
		oam_ptr = '0;
		read_buf = '0;
		dot_count = 0;
		mirror_sh = 12'hfff;
		foreach (oam_sh[i]) oam_sh[i] = '0;
		foreach (nt_sh[i]) nt_sh[i] = '0;
		foreach (pal_sh[i]) pal_sh[i] = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		set_mirror(12'hfff);

		// directed: field extremes, every register, the awkward corners
		put(mk(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_CTRL, 8'h00, 8'h00));
		put(mk(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_MASK, 8'h00, 8'hff));
		put(mk(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_OAMADR, 8'hff, 8'h00));
		put(mk(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_OAMDAT, 8'hab, 8'h00)); // oam pointer wraps
		put(mk(vrsa_pkg::FUNC_READ, vrsa_pkg::REG_OAMDAT, 8'h00, 8'h00));
		put(mk(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_SCROLL, 8'hff, 8'h00));
		put(mk(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_SCROLL, 8'h00, 8'h00));
		put(mk(vrsa_pkg::FUNC_READ, vrsa_pkg::REG_STATUS, 8'hff, 8'hff));
		put(mk(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_ADDR, 8'h3f, 8'h00));
		put(mk(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_ADDR, 8'h10, 8'h00));
		// mirrored palette slot, top bits dropped
		put(mk(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_DATA, 8'hff, 8'h00));
		// top address bits beyond 14 dropped
		put(mk(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_ADDR, 8'hff, 8'h00));
		put(mk(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_ADDR, 8'h00, 8'h00));
		// palette read, single increment
		put(mk(vrsa_pkg::FUNC_READ, vrsa_pkg::REG_DATA, 8'h00, 8'h00));
		put(mk(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_ADDR, 8'h1f, 8'h00));
		put(mk(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_ADDR, 8'hff, 8'h00));
		put(mk(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_DATA, 8'h5a, 8'h00)); // pattern write
		put(mk(vrsa_pkg::FUNC_READ, vrsa_pkg::REG_DATA, 8'h00, 8'hff));
		put(mk(vrsa_pkg::FUNC_READ, vrsa_pkg::REG_DATA, 8'h00, 8'h00));
		put(mk(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_CTRL, 8'hff, 8'h00)); // step by 32
		put(mk(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_DATA, 8'h77, 8'h00));
		put(mk(vrsa_pkg::FUNC_WRITE, vrsa_pkg::REG_STATUS, 8'hff, 8'h00));
		// write-only register reads zero
		put(mk(vrsa_pkg::FUNC_READ, vrsa_pkg::REG_CTRL, 8'h00, 8'h00));
		put(mk(FUNC_SPARE, vrsa_pkg::REG_DATA, 8'hff, 8'hff));
		put(mk(vrsa_pkg::FUNC_TICK, vrsa_pkg::REG_CTRL, 8'h00, 8'h00));
		wait_idle();

		// random phases across mirroring settings, idle between each
		masks[0] = 12'h000;
		masks[1] = 12'hfff;
		masks[2] = 12'h7ff;
		masks[3] = 12'hbff;
		masks[4] = 12'($urandom);
		masks[5] = 12'h3ff;
		foreach (masks[p]) begin
			set_mirror(masks[p]);
			stop_at = queued + RANDOM_WORDS / 6;
			while (queued < stop_at)
				put_group();
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("video_register_port_and_scroll_address_unit: match");
		else
			$display("video_register_port_and_scroll_address_unit: mismatch");
		$finish;
	end

endmodule

### video_register_port_and_scroll_address_unit.f
rtl/vrsa_pkg.sv
rtl/vrsa_oam_ram.sv
rtl/vrsa_nt_ram.sv
rtl/video_register_port_and_scroll_address_unit.sv
tb/tb_video_register_port_and_scroll_address_unit.sv
